>>> hw/rtl/rfps_pkg.sv
// ----------------------------------------------------------------------------
// Round-fair priority scheduler package
// Field widths, command codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rfps_pkg;

   // Payload field widths.
   localparam int CMD_W        = 3;
   localparam int OP_FIELD_W   = 6;
   localparam int GRP_FIELD_W  = 3;
   localparam int RANK_W       = 16;
   localparam int WHOLE_W      = 32;
   localparam int CUR_ROUND_W  = 32;

   // Request command codes; the remaining codes are no-ops.
   typedef enum logic [CMD_W-1:0] {
      CMD_QUERY      = 3'd0,
      CMD_COMPLETE   = 3'd1,
      CMD_REGISTER   = 3'd2,
      CMD_ACTIVATE   = 3'd3,
      CMD_DEACTIVATE = 3'd4
   } cmd_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_ADVANCE,
      ST_PRIORITY,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic lookup;
      logic scan;
      logic advance;
      logic priority_calc;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic go_scan;
      logic scan_done;
      logic rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/rfps_req_if.sv
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one scheduler command and its operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfps_req_if;
   logic                               valid;
   logic                               ready;
   logic [rfps_pkg::CMD_W-1:0]         cmd;
   logic [rfps_pkg::OP_FIELD_W-1:0]    operator_index;
   logic [rfps_pkg::GRP_FIELD_W-1:0]   group_index;
   logic [rfps_pkg::RANK_W-1:0]        rank_fraction;

   modport source (output valid, cmd, operator_index, group_index, rank_fraction,
                   input ready);
   modport sink   (input valid, cmd, operator_index, group_index, rank_fraction,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rfps_rsp_if.sv
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel carrying the priority and round for one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rfps_pkg::WHOLE_W-1:0]       priority_whole;
   logic [rfps_pkg::RANK_W-1:0]        priority_fraction;
   logic [rfps_pkg::CUR_ROUND_W-1:0]   current_round;
   logic                               unknown_operator;

   modport source (output valid, priority_whole, priority_fraction, current_round,
                   unknown_operator, input ready);
   modport sink   (input valid, priority_whole, priority_fraction, current_round,
                   unknown_operator, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rfps_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences each request through lookup and, for a query on an active operator,
// the completion scan, round advance and priority, then output register load.
// ----------------------------------------------------------------------------
`default_nettype none

module rfps_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire rfps_pkg::dp_status_type status,
   output logic                         req_ready,
   output rfps_pkg::ctrl_cmd_type       cmd
);

   rfps_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rfps_pkg::ST_IDLE: begin
            if (req_valid) state_in = rfps_pkg::ST_LOOKUP;
         end
         rfps_pkg::ST_LOOKUP: begin
            state_in = status.go_scan ? rfps_pkg::ST_SCAN : rfps_pkg::ST_DONE;
         end
         rfps_pkg::ST_SCAN: begin
            if (status.scan_done) state_in = rfps_pkg::ST_ADVANCE;
         end
         rfps_pkg::ST_ADVANCE: begin
            state_in = rfps_pkg::ST_PRIORITY;
         end
         rfps_pkg::ST_PRIORITY: begin
            state_in = rfps_pkg::ST_DONE;
         end
         rfps_pkg::ST_DONE: begin
            if (!status.rsp_busy) state_in = rfps_pkg::ST_IDLE;
         end
         default: begin
            state_in = rfps_pkg::ST_IDLE;
         end
      endcase
   end

   // Output decode.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rfps_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         rfps_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         rfps_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         rfps_pkg::ST_ADVANCE: begin
            cmd.advance = 1'b1;
         end
         rfps_pkg::ST_PRIORITY: begin
            cmd.priority_calc = 1'b1;
         end
         rfps_pkg::ST_DONE: begin
            cmd.load_rsp = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/rfps_dp.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Holds the operator table, the valid and group-active flags, the global
// round, the completion scan and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfps_dp #(
   parameter int MAX_OPERATORS = 64,
   parameter int MAX_GROUPS    = 8,
   parameter int ROUND_BITS    = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rfps_pkg::ctrl_cmd_type              cmd,
   output rfps_pkg::dp_status_type                  status,
   // Request payload.
   input  wire logic [rfps_pkg::CMD_W-1:0]          req_cmd,
   input  wire logic [rfps_pkg::OP_FIELD_W-1:0]     req_operator_index,
   input  wire logic [rfps_pkg::GRP_FIELD_W-1:0]    req_group_index,
   input  wire logic [rfps_pkg::RANK_W-1:0]         req_rank_fraction,
   // Response register.
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic [rfps_pkg::WHOLE_W-1:0]             rsp_priority_whole,
   output logic [rfps_pkg::RANK_W-1:0]              rsp_priority_fraction,
   output logic [rfps_pkg::CUR_ROUND_W-1:0]         rsp_current_round,
   output logic                                     rsp_unknown_operator
);

   localparam int OP_W    = $clog2(MAX_OPERATORS);
   localparam int SCAN_W  = OP_W + 1;
   localparam int GRP_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int ENTRY_W = rfps_pkg::GRP_FIELD_W + rfps_pkg::RANK_W + ROUND_BITS;

   // True when a has reached b, judged by the sign of the wrapped difference.
   function automatic logic round_reached(input logic [ROUND_BITS-1:0] a,
                                          input logic [ROUND_BITS-1:0] b);
      logic [ROUND_BITS-1:0] diff;
      diff = a - b;
      return !diff[ROUND_BITS-1];
   endfunction

   // Captured request.
   logic [rfps_pkg::CMD_W-1:0]        cmd_ff;
   logic [rfps_pkg::OP_FIELD_W-1:0]   op_ff;
   logic [rfps_pkg::GRP_FIELD_W-1:0]  grp_ff;
   logic [rfps_pkg::RANK_W-1:0]       rank_ff;

   // Operator table memory and its registered read data.
   logic [ENTRY_W-1:0]  entry_mem_ff [MAX_OPERATORS];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [OP_W-1:0]     mem_raddr;
   logic                mem_we;
   logic [OP_W-1:0]     mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;

   // Control state.
   logic [MAX_OPERATORS-1:0]  valid_ff, valid_in;
   logic [MAX_GROUPS-1:0]     active_ff, active_in;
   logic [ROUND_BITS-1:0]     round_ff, round_in;
   logic [SCAN_W-1:0]         scan_addr_ff, scan_addr_in;
   logic                      chk_vld_ff, chk_vld_in;
   logic [OP_W-1:0]           chk_idx_ff, chk_idx_in;
   logic                      blocked_ff, blocked_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Working registers of the current request.
   logic [rfps_pkg::RANK_W-1:0]  op_rank_ff, op_rank_in;
   logic [ROUND_BITS-1:0]        op_rounds_ff, op_rounds_in;
   logic [rfps_pkg::WHOLE_W-1:0] whole_ff, whole_in;
   logic [rfps_pkg::RANK_W-1:0]  frac_ff, frac_in;
   logic                         unk_ff, unk_in;

   // Output payload registers.
   logic [rfps_pkg::WHOLE_W-1:0]     out_whole_ff;
   logic [rfps_pkg::RANK_W-1:0]      out_frac_ff;
   logic [rfps_pkg::CUR_ROUND_W-1:0] out_round_ff;
   logic                             out_unk_ff;

   // Decoded fields.
   logic [31:0]                       op_wide, req_op_wide, grp_wide, rd_grp_wide;
   logic [OP_W-1:0]                   op_idx;
   logic [GRP_W-1:0]                  grp_idx, rd_grp_idx;
   logic                              op_ok, grp_ok, known;
   logic [rfps_pkg::GRP_FIELD_W-1:0]  rd_group;
   logic [rfps_pkg::RANK_W-1:0]       rd_rank;
   logic [ROUND_BITS-1:0]             rd_rounds;
   logic                              rd_active;
   logic [ROUND_BITS-1:0]             behind;
   logic [63:0]                       behind_wide;
   logic [63:0]                       round_wide;
   logic                              go_scan;

   assign op_wide     = 32'(op_ff);
   assign req_op_wide = 32'(req_operator_index);
   assign grp_wide    = 32'(grp_ff);
   assign op_idx      = op_wide[OP_W-1:0];
   assign grp_idx     = grp_wide[GRP_W-1:0];
   assign op_ok       = op_wide < 32'(MAX_OPERATORS);
   assign grp_ok      = grp_wide < 32'(MAX_GROUPS);
   assign known       = op_ok && valid_ff[op_idx];

   assign rd_group    = rd_data_ff[ENTRY_W-1 -: rfps_pkg::GRP_FIELD_W];
   assign rd_rank     = rd_data_ff[ROUND_BITS +: rfps_pkg::RANK_W];
   assign rd_rounds   = rd_data_ff[ROUND_BITS-1:0];
   assign rd_grp_wide = 32'(rd_group);
   assign rd_grp_idx  = rd_grp_wide[GRP_W-1:0];
   assign rd_active   = active_ff[rd_grp_idx];

   assign behind      = round_ff - op_rounds_ff;
   assign behind_wide = 64'(behind);
   assign round_wide  = 64'(round_ff);

   // Read the named operator on capture, the scan entry while scanning.
   assign mem_raddr = cmd.scan ? scan_addr_ff[OP_W-1:0] : req_op_wide[OP_W-1:0];

   // Operator table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem_ff[mem_raddr];
   end

   // Command execution, scan and round update.
   always_comb begin
      valid_in     = valid_ff;
      active_in    = active_ff;
      round_in     = round_ff;
      scan_addr_in = scan_addr_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      blocked_in   = blocked_ff;
      op_rank_in   = op_rank_ff;
      op_rounds_in = op_rounds_ff;
      whole_in     = whole_ff;
      frac_in      = frac_ff;
      unk_in       = unk_ff;
      mem_we       = 1'b0;
      mem_waddr    = op_idx;
      mem_wdata    = {rd_group, rd_rank, rd_rounds};
      go_scan      = 1'b0;

      // A new request starts with an all-zero result.
      if (cmd.capture) begin
         whole_in = '0;
         frac_in  = '0;
         unk_in   = 1'b0;
      end

      // Dispatch on the command once the operator's entry has been read.
      if (cmd.lookup) begin
         op_rank_in   = rd_rank;
         op_rounds_in = rd_rounds;
         scan_addr_in = '0;
         blocked_in   = 1'b0;
         case (cmd_ff)
            rfps_pkg::CMD_QUERY: begin
               unk_in  = !known;
               go_scan = known && rd_active;
            end
            rfps_pkg::CMD_COMPLETE: begin
               unk_in = !known;
               if (known) begin
                  mem_we    = 1'b1;
                  mem_wdata = {rd_group, rd_rank, rd_rounds + 1'b1};
               end
            end
            rfps_pkg::CMD_REGISTER: begin
               unk_in = !op_ok;
               if (op_ok && grp_ok) begin
                  mem_we           = 1'b1;
                  mem_wdata        = {grp_ff, rank_ff, round_ff};
                  valid_in[op_idx] = 1'b1;
               end
            end
            rfps_pkg::CMD_ACTIVATE: begin
               if (grp_ok) active_in[grp_idx] = 1'b1;
            end
            rfps_pkg::CMD_DEACTIVATE: begin
               if (grp_ok) active_in[grp_idx] = 1'b0;
            end
            default: begin
               unk_in = 1'b0;
            end
         endcase
      end

      // Scan: issue one read per cycle, check the entry read the cycle before.
      if (cmd.scan) begin
         if (scan_addr_ff != SCAN_W'(MAX_OPERATORS)) begin
            chk_vld_in   = 1'b1;
            chk_idx_in   = scan_addr_ff[OP_W-1:0];
            scan_addr_in = scan_addr_ff + 1'b1;
         end
         if (chk_vld_ff && valid_ff[chk_idx_ff] && rd_active &&
             !round_reached(rd_rounds, round_ff)) begin
            blocked_in = 1'b1;
         end
      end

      // Every active operator has finished the round: move to the next one.
      if (cmd.advance && !blocked_ff) begin
         round_in = round_ff + 1'b1;
      end

      // Rounds behind, clamped at zero and at the top of the whole part.
      if (cmd.priority_calc) begin
         frac_in = op_rank_ff;
         if (!behind[ROUND_BITS-1]) begin
            whole_in = (behind_wide > 64'hFFFF_FFFF) ? '1 : behind_wide[31:0];
         end
      end
   end

   assign status.go_scan   = go_scan;
   assign status.scan_done = (scan_addr_ff == SCAN_W'(MAX_OPERATORS)) && !chk_vld_ff;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

   // Output register handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         active_ff    <= '0;
         round_ff     <= '0;
         scan_addr_ff <= '0;
         chk_vld_ff   <= 1'b0;
         blocked_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         active_ff    <= active_in;
         round_ff     <= round_in;
         scan_addr_ff <= scan_addr_in;
         chk_vld_ff   <= chk_vld_in;
         blocked_ff   <= blocked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         op_ff   <= req_operator_index;
         grp_ff  <= req_group_index;
         rank_ff <= req_rank_fraction;
      end
      chk_idx_ff   <= chk_idx_in;
      op_rank_ff   <= op_rank_in;
      op_rounds_ff <= op_rounds_in;
      whole_ff     <= whole_in;
      frac_ff      <= frac_in;
      unk_ff       <= unk_in;
      if (cmd.load_rsp) begin
         out_whole_ff <= whole_ff;
         out_frac_ff  <= frac_ff;
         out_round_ff <= round_wide[31:0];
         out_unk_ff   <= unk_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_priority_whole    = out_whole_ff;
   assign rsp_priority_fraction = out_frac_ff;
   assign rsp_current_round     = out_round_ff;
   assign rsp_unknown_operator  = out_unk_ff;

endmodule

`default_nettype wire

>>> hw/rtl/round_fair_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Round-fair priority scheduler
// Tracks a global round and per-operator completed rounds, and answers
// priority queries as rounds behind (whole part) plus a rank fraction.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_ch (valid/ready): query, completion, register,
//   activate group or deactivate group. Every request yields exactly one
//   response on rsp_ch with the priority, the round after the request and an
//   unknown-operator flag.
//   A query on an active operator scans the whole operator table, one entry
//   per cycle through the table's single read port; all other requests skip
//   the scan.
//   Throughput: one request at a time; req_ch.ready is high while the block
//   is idle. A new request is accepted while the previous response still sits
//   in the output register, and is held before its own response until that
//   register is free.
//   Reset clears all registrations, all group flags and the round to zero.
//   A stalled receiver holds the response stable until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module round_fair_priority_scheduler #(
   parameter int MAX_OPERATORS = 64,
   parameter int MAX_GROUPS    = 8,
   parameter int ROUND_BITS    = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   rfps_req_if.sink   req_ch,
   rfps_rsp_if.source rsp_ch
);

   rfps_pkg::ctrl_cmd_type  ctrl_cmd;
   rfps_pkg::dp_status_type dp_status;
   logic                    ready;

   // Sequencer.
   rfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (dp_status),
      .req_ready (ready),
      .cmd       (ctrl_cmd)
   );

   assign req_ch.ready = ready;

   // Table, flags, round and output register.
   rfps_dp #(
      .MAX_OPERATORS (MAX_OPERATORS),
      .MAX_GROUPS    (MAX_GROUPS),
      .ROUND_BITS    (ROUND_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (ctrl_cmd),
      .status                (dp_status),
      .req_cmd               (req_ch.cmd),
      .req_operator_index    (req_ch.operator_index),
      .req_group_index       (req_ch.group_index),
      .req_rank_fraction     (req_ch.rank_fraction),
      .rsp_ready             (rsp_ch.ready),
      .rsp_valid             (rsp_ch.valid),
      .rsp_priority_whole    (rsp_ch.priority_whole),
      .rsp_priority_fraction (rsp_ch.priority_fraction),
      .rsp_current_round     (rsp_ch.current_round),
      .rsp_unknown_operator  (rsp_ch.unknown_operator)
   );

endmodule

`default_nettype wire

>>> hw/rtl/rfps_checker.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the request and response channels of the scheduler top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rfps_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [rfps_pkg::WHOLE_W-1:0]        rsp_priority_whole,
   input wire logic [rfps_pkg::RANK_W-1:0]         rsp_priority_fraction,
   input wire logic [rfps_pkg::CUR_ROUND_W-1:0]    rsp_current_round,
   input wire logic                                rsp_unknown_operator
);

   logic                                req_fire, rsp_fire;
   logic [1:0]                          pending_ff, pending_in;
   logic [rfps_pkg::CUR_ROUND_W-1:0]    last_round_ff, last_round_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Requests accepted but not yet answered, and the last round seen.
   always_comb begin
      pending_in    = pending_ff + 2'(req_fire) - 2'(rsp_fire);
      last_round_in = rsp_fire ? rsp_current_round : last_round_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         last_round_ff <= '0;
      end else begin
         pending_ff    <= pending_in;
         last_round_ff <= last_round_in;
      end
   end

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_priority_whole) &&
         $stable(rsp_priority_fraction) && $stable(rsp_current_round) &&
         $stable(rsp_unknown_operator))
      else $error("response changed while stalled");

   // An unknown operator never gets a priority.
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unknown_operator |->
         rsp_priority_whole == '0 && rsp_priority_fraction == '0)
      else $error("unknown operator returned a nonzero priority");

   // The round moves by at most one per request.
   a_round_step: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> rsp_current_round == last_round_ff ||
                   rsp_current_round == last_round_ff + 1'b1)
      else $error("round jumped by more than one");

   // No response without an accepted request behind it.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a pending request");

endmodule

bind round_fair_priority_scheduler rfps_checker u_rfps_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_ch.valid),
   .req_ready             (req_ch.ready),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_priority_whole    (rsp_ch.priority_whole),
   .rsp_priority_fraction (rsp_ch.priority_fraction),
   .rsp_current_round     (rsp_ch.current_round),
   .rsp_unknown_operator  (rsp_ch.unknown_operator)
);

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Round-fair priority scheduler testbench
// Drives scheduler requests through the request channel and checks every
// response against an in-bench prediction of the operator table, the group
// flags and the global round. Directed requests come first, followed by
// random registration, completion and query sequences mixed with noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_COUNT     = 64;
   localparam int GROUP_COUNT  = 8;
   localparam int RANDOM_ITEMS = 900;
   localparam int TAIL_ITEMS   = 60;
   localparam int DRAIN_CYCLES = 80;

   // Command codes the block treats as no-ops.
   localparam logic [rfps_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
   localparam logic [rfps_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
   localparam logic [rfps_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

   typedef struct {
      logic [rfps_pkg::CMD_W-1:0]       cmd;
      logic [rfps_pkg::OP_FIELD_W-1:0]  op;
      logic [rfps_pkg::GRP_FIELD_W-1:0] grp;
      logic [rfps_pkg::RANK_W-1:0]      rank;
   } sched_request_type;

   typedef struct {
      logic [rfps_pkg::WHOLE_W-1:0]     whole;
      logic [rfps_pkg::RANK_W-1:0]      frac;
      logic [rfps_pkg::CUR_ROUND_W-1:0] round;
      logic                             unknown;
   } sched_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rfps_req_if req_ch ();
   rfps_rsp_if rsp_ch ();

   round_fair_priority_scheduler #(
      .MAX_OPERATORS(OP_COUNT),
      .MAX_GROUPS   (GROUP_COUNT),
      .ROUND_BITS   (32)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted scheduler state.
   logic                             op_known  [OP_COUNT];
   logic [rfps_pkg::GRP_FIELD_W-1:0] op_group  [OP_COUNT];
   logic [rfps_pkg::RANK_W-1:0]      op_rank   [OP_COUNT];
   logic [31:0]                      op_rounds [OP_COUNT];
   logic                             group_on  [GROUP_COUNT];
   logic [31:0]                      round_now = '0;

   sched_request_type  pending_requests[$];
   sched_response_type expected_responses[$];
   sched_request_type  request_on_bus;

   int total_items    = 0;
   int accepted_count = 0;
   int fail_count     = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   logic send_gaps_on = 1'b1;
   logic stalls_on    = 1'b1;
   logic quiet_tail;

   assign quiet_tail = (total_items - accepted_count) <= TAIL_ITEMS;

   // Applies one request to the predicted state and returns its response.
   function automatic sched_response_type predict_response(input sched_request_type r);
      sched_response_type rsp;
      logic [31:0]        lag;
      logic               all_caught_up;
      int                 i;
      rsp = '{whole: '0, frac: '0, round: '0, unknown: 1'b0};
      case (r.cmd)
         rfps_pkg::CMD_QUERY: begin
            if (!op_known[r.op]) begin
               rsp.unknown = 1'b1;
            end else if (group_on[op_group[r.op]]) begin
               // The round moves on once every active operator has caught up.
               all_caught_up = 1'b1;
               for (i = 0; i < OP_COUNT; i++) begin
                  if (op_known[i] && group_on[op_group[i]]) begin
                     lag = op_rounds[i] - round_now;
                     if (lag[31]) all_caught_up = 1'b0;
                  end
               end
               if (all_caught_up) round_now = round_now + 32'd1;
               lag = round_now - op_rounds[r.op];
               rsp.whole = lag[31] ? '0 : lag;
               rsp.frac  = op_rank[r.op];
            end
         end
         rfps_pkg::CMD_COMPLETE: begin
            if (!op_known[r.op]) rsp.unknown = 1'b1;
            else op_rounds[r.op] = op_rounds[r.op] + 32'd1;
         end
         rfps_pkg::CMD_REGISTER: begin
            op_known[r.op]  = 1'b1;
            op_group[r.op]  = r.grp;
            op_rank[r.op]   = r.rank;
            op_rounds[r.op] = round_now;
         end
         rfps_pkg::CMD_ACTIVATE:   group_on[r.grp] = 1'b1;
         rfps_pkg::CMD_DEACTIVATE: group_on[r.grp] = 1'b0;
         default: ;
      endcase
      rsp.round = round_now;
      return rsp;
   endfunction

   // Queues one request; the operands are cut to their field widths here.
   task automatic add_request(input logic [rfps_pkg::CMD_W-1:0] c, input int op,
                              input int grp, input int rank);
      sched_request_type r;
      r.cmd  = c;
      r.op   = op[rfps_pkg::OP_FIELD_W-1:0];
      r.grp  = grp[rfps_pkg::GRP_FIELD_W-1:0];
      r.rank = rank[rfps_pkg::RANK_W-1:0];
      pending_requests.push_back(r);
   endtask

   // Any request at all, spare command codes included.
   task automatic add_noise();
      int code;
      code = $urandom_range(0, 7);
      add_request(code[rfps_pkg::CMD_W-1:0], $urandom_range(0, OP_COUNT - 1),
                  $urandom_range(0, GROUP_COUNT - 1), $urandom_range(0, 'hFFFF));
   endtask

   // One episode: register a pool of operators, activate their groups and run
   // a few rounds of completions and queries over them.
   task automatic run_episode();
      int pool[$];
      int pool_size;
      int rounds;
      int k;
      int g;
      int roll;
      pool_size = $urandom_range(1, 6);
      for (k = 0; k < pool_size; k++) begin
         pool.push_back($urandom_range(0, OP_COUNT - 1));
         g = $urandom_range(0, GROUP_COUNT - 1);
         add_request(rfps_pkg::CMD_REGISTER, pool[k], g, $urandom_range(0, 'hFFFF));
         add_request(rfps_pkg::CMD_ACTIVATE, $urandom_range(0, OP_COUNT - 1), g, $urandom);
      end
      rounds = $urandom_range(1, 6);
      repeat (rounds) begin
         for (k = 0; k < pool_size; k++) begin
            if ($urandom_range(0, 2) == 0)
               add_request(rfps_pkg::CMD_QUERY, pool[$urandom_range(0, pool_size - 1)],
                           $urandom, $urandom);
            roll = $urandom_range(0, 19);
            if (roll < 19)
               add_request(rfps_pkg::CMD_COMPLETE, pool[k], $urandom, $urandom);
            if (roll >= 17)
               add_request(rfps_pkg::CMD_COMPLETE, pool[k], $urandom, $urandom);
            if ($urandom_range(0, 5) == 0) add_noise();
         end
         add_request(rfps_pkg::CMD_QUERY, pool[$urandom_range(0, pool_size - 1)],
                     $urandom, $urandom);
         // Occasionally toggle a group or re-register a pool member.
         roll = $urandom_range(0, 9);
         if (roll == 0)
            add_request(rfps_pkg::CMD_DEACTIVATE, $urandom,
                        $urandom_range(0, GROUP_COUNT - 1), $urandom);
         else if (roll == 1)
            add_request(rfps_pkg::CMD_ACTIVATE, $urandom,
                        $urandom_range(0, GROUP_COUNT - 1), $urandom);
         else if (roll == 2)
            add_request(rfps_pkg::CMD_REGISTER, pool[$urandom_range(0, pool_size - 1)],
                        $urandom_range(0, GROUP_COUNT - 1), $urandom_range(0, 'hFFFF));
      end
      // Clearing every group keeps stale operators from blocking the round.
      if ($urandom_range(0, 1) == 0) begin
         for (g = 0; g < GROUP_COUNT; g++)
            add_request(rfps_pkg::CMD_DEACTIVATE, $urandom, g, $urandom);
      end
   endtask

   // Directed requests: unknown operators, spare codes, inactive groups, round
   // advance, negative lag, re-registration and field extremes.
   task automatic add_directed();
      add_request(rfps_pkg::CMD_QUERY, 5, 0, 'h0000);
      add_request(rfps_pkg::CMD_COMPLETE, 63, 7, 'hFFFF);
      add_request(CMD_SPARE_LO, 0, 0, 'h0000);
      add_request(CMD_SPARE_MID, 21, 5, 'h5555);
      add_request(CMD_SPARE_HI, 63, 7, 'hFFFF);
      add_request(rfps_pkg::CMD_REGISTER, 0, 0, 'h0000);
      add_request(rfps_pkg::CMD_REGISTER, 63, 7, 'hFFFF);
      add_request(rfps_pkg::CMD_QUERY, 0, 0, 'h0000);
      add_request(rfps_pkg::CMD_ACTIVATE, 0, 0, 'h0000);
      add_request(rfps_pkg::CMD_ACTIVATE, 63, 7, 'hFFFF);
      add_request(rfps_pkg::CMD_QUERY, 0, 2, 'hAAAA);
      add_request(rfps_pkg::CMD_QUERY, 63, 5, 'h5555);
      add_request(rfps_pkg::CMD_COMPLETE, 0, 0, 'h0000);
      add_request(rfps_pkg::CMD_COMPLETE, 63, 0, 'h0000);
      add_request(rfps_pkg::CMD_QUERY, 63, 0, 'h0000);
      // Operator 0 runs ahead of the round, so its lag goes negative.
      repeat (3) add_request(rfps_pkg::CMD_COMPLETE, 0, 0, 'h0000);
      add_request(rfps_pkg::CMD_QUERY, 0, 0, 'h0000);
      add_request(rfps_pkg::CMD_DEACTIVATE, 0, 7, 'h0000);
      add_request(rfps_pkg::CMD_QUERY, 0, 0, 'h0000);
      add_request(rfps_pkg::CMD_QUERY, 63, 0, 'h0000);
      add_request(rfps_pkg::CMD_REGISTER, 63, 0, 'h8001);
      add_request(rfps_pkg::CMD_QUERY, 63, 0, 'h0000);
      add_request(rfps_pkg::CMD_DEACTIVATE, 0, 0, 'h0000);
      add_request(rfps_pkg::CMD_COMPLETE, 32, 0, 'h0000);
      add_request(rfps_pkg::CMD_QUERY, 32, 0, 'h0000);
   endtask

   // Request driver: predicts each accepted request and presents the next one.
   always @(posedge clock) begin
      logic drive_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         drive_valid = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            expected_responses.push_back(predict_response(request_on_bus));
            accepted_count++;
            drive_valid = 1'b0;
         end
         if (!drive_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() != 0) begin
               if (!quiet_tail && send_gaps_on && $urandom_range(0, 6) == 0) begin
                  send_gap = $urandom_range(0, 13);
               end else begin
                  request_on_bus = pending_requests.pop_front();
                  req_ch.cmd            <= request_on_bus.cmd;
                  req_ch.operator_index <= request_on_bus.op;
                  req_ch.group_index    <= request_on_bus.grp;
                  req_ch.rank_fraction  <= request_on_bus.rank;
                  drive_valid = 1'b1;
                  if ($urandom_range(0, 39) == 0) send_gaps_on = !send_gaps_on;
               end
            end
         end
         req_ch.valid <= drive_valid;
      end
   end

   // Response monitor: checks each accepted response and throttles ready.
   always @(posedge clock) begin
      sched_response_type want;
      logic               take;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_ch.priority_whole !== want.whole) begin
                  $error("priority_whole: expected %0d, actual %0d", want.whole,
                         rsp_ch.priority_whole);
                  fail_count++;
               end
               if (rsp_ch.priority_fraction !== want.frac) begin
                  $error("priority_fraction: expected %0h, actual %0h", want.frac,
                         rsp_ch.priority_fraction);
                  fail_count++;
               end
               if (rsp_ch.current_round !== want.round) begin
                  $error("current_round: expected %0d, actual %0d", want.round,
                         rsp_ch.current_round);
                  fail_count++;
               end
               if (rsp_ch.unknown_operator !== want.unknown) begin
                  $error("unknown_operator: expected %0b, actual %0b", want.unknown,
                         rsp_ch.unknown_operator);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            take = 1'b0;
         end else if (!quiet_tail && stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         if ($urandom_range(0, 59) == 0) stalls_on = !stalls_on;
         rsp_ch.ready <= take;
      end
   end

   // Stimulus build, reset and end of run.
   initial begin
      int i;
      req_ch.valid          = 1'b0;
      req_ch.cmd            = '0;
      req_ch.operator_index = '0;
      req_ch.group_index    = '0;
      req_ch.rank_fraction  = '0;
      rsp_ch.ready          = 1'b0;
      for (i = 0; i < OP_COUNT; i++) begin
         op_known[i]  = 1'b0;
         op_group[i]  = '0;
         op_rank[i]   = '0;
         op_rounds[i] = '0;
      end
      for (i = 0; i < GROUP_COUNT; i++) group_on[i] = 1'b0;

      add_directed();
      i = pending_requests.size();
      while (pending_requests.size() < i + RANDOM_ITEMS) begin
         if ($urandom_range(0, 6) == 0) add_noise();
         else run_episode();
      end
      total_items = pending_requests.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
